### rtl/npcs_pkg.sv
// npcs_pkg: types, constants and the distance function shared by the
// nearest palette color search unit and its cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

    localparam int COMP_W = 8;
    localparam int SLOT_W = 4;
    localparam int DIST_W = 18;
    localparam int SIZE_W = 5;

    typedef enum logic [0:0]
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    // Search token handed from cell to cell.
    typedef struct packed
    {
        rgb_t              ref_color;
        rgb_t              best_color;
        logic [SLOT_W-1:0] best_slot;
        logic [DIST_W-1:0] best_dist;
    } token_t;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    function automatic logic [DIST_W-1:0] sq_dist(rgb_t a, rgb_t b);
        logic [COMP_W-1:0]   dr;
        logic [COMP_W-1:0]   dg;
        logic [COMP_W-1:0]   db;
        logic [2*COMP_W-1:0] sr;
        logic [2*COMP_W-1:0] sg;
        logic [2*COMP_W-1:0] sb;
        dr = (a.red   >= b.red)   ? (a.red   - b.red)   : (b.red   - a.red);
        dg = (a.green >= b.green) ? (a.green - b.green) : (b.green - a.green);
        db = (a.blue  >= b.blue)  ? (a.blue  - b.blue)  : (b.blue  - a.blue);
        sr = {{COMP_W{1'b0}}, dr} * {{COMP_W{1'b0}}, dr};
        sg = {{COMP_W{1'b0}}, dg} * {{COMP_W{1'b0}}, dg};
        sb = {{COMP_W{1'b0}}, db} * {{COMP_W{1'b0}}, db};
        return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    endfunction

endpackage

`default_nettype wire

### rtl/npcs_if.sv
// npcs_item_if and npcs_result_if: valid/ready channels of the search unit.
// Depends on npcs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface npcs_item_if;
    logic                            valid;
    logic                            ready;
    logic [0:0]                      cmd;
    logic [npcs_pkg::SLOT_W-1:0]     entry_index;
    logic [npcs_pkg::COMP_W-1:0]     in_red;
    logic [npcs_pkg::COMP_W-1:0]     in_green;
    logic [npcs_pkg::COMP_W-1:0]     in_blue;

    modport source (output valid, cmd, entry_index, in_red, in_green, in_blue,
                    input ready);
    modport sink   (input valid, cmd, entry_index, in_red, in_green, in_blue,
                    output ready);
endinterface

interface npcs_result_if;
    logic                            valid;
    logic                            ready;
    logic [npcs_pkg::COMP_W-1:0]     near_red;
    logic [npcs_pkg::COMP_W-1:0]     near_green;
    logic [npcs_pkg::COMP_W-1:0]     near_blue;
    logic [npcs_pkg::SLOT_W-1:0]     near_index;
    logic [npcs_pkg::DIST_W-1:0]     near_sq_distance;

    modport source (output valid, near_red, near_green, near_blue, near_index,
                    near_sq_distance, input ready);
    modport sink   (input valid, near_red, near_green, near_blue, near_index,
                    near_sq_distance, output ready);
endinterface

`default_nettype wire

### rtl/npcs_cell.sv
// npcs_cell: one palette slot of the search chain. Holds its entry, compares
// the passing token against it and hands the token on. Depends on npcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npcs_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            wr_en,
    input  wire npcs_pkg::rgb_t  wr_color,
    input  wire logic            active,
    input  wire logic            tok_in_valid,
    input  wire npcs_pkg::token_t tok_in,
    output logic                 tok_out_valid,
    output npcs_pkg::token_t     tok_out
);

    npcs_pkg::rgb_t                entry_reg;
    logic                          valid_reg;
    npcs_pkg::token_t              tok_reg;
    npcs_pkg::token_t              tok_next;
    logic [npcs_pkg::DIST_W-1:0]   cell_dist;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_color;
        end
    end

    always_comb
    begin
        cell_dist = npcs_pkg::sq_dist(entry_reg, tok_in.ref_color);
        tok_next  = tok_in;
        if (active && (cell_dist < tok_in.best_dist))
        begin
            tok_next.best_color = entry_reg;
            tok_next.best_slot  = npcs_pkg::SLOT_W'(CELL_IDX);
            tok_next.best_dist  = cell_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = valid_reg;
    assign tok_out       = tok_reg;

endmodule

`default_nettype wire

### rtl/nearest_palette_color_search_unit.sv
// nearest_palette_color_search_unit: top level, a chain of palette cells,
// the search size register and the result register.
// Depends on npcs_pkg, npcs_if (npcs_item_if, npcs_result_if) and npcs_cell.
`timescale 1ns / 1ps
`default_nettype none

// A load transfer writes one palette slot and gives no result. A query
// transfer enters a chain of PALETTE_DEPTH cells, one slot per cell, and
// moves one cell per cycle while the chain is not held; cells beyond the
// search size pass it on untouched. Whatever the search size, the token
// passes every cell register in order and then lands in the output
// register, and the item channel takes the next transfer once it has
// landed. A result waiting in the output register does not block a
// further query; the chain only holds when its finished token meets a
// full output register. Slots that were never loaded read back as
// undefined. There is no clearing pass.
module nearest_palette_color_search_unit #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    npcs_item_if.sink                          item,
    npcs_result_if.source                      result,
    input  wire logic                          cfg_wr_en,
    input  wire logic [npcs_pkg::SIZE_W-1:0]   cfg_wr_data
);

    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    logic [npcs_pkg::SIZE_W-1:0] palette_size_reg;
    logic [npcs_pkg::SIZE_W-1:0] size_nz;
    logic [CNT_W-1:0]            eff_count;

    logic                        busy_reg;
    logic                        busy_next;
    logic                        item_xfer;
    logic                        load_xfer;
    logic                        query_xfer;
    logic                        advance;
    logic                        out_load;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    npcs_pkg::token_t            out_tok_reg;

    npcs_pkg::rgb_t              in_color;
    npcs_pkg::token_t            head_tok;
    logic [PALETTE_DEPTH:0]      chain_valid;
    npcs_pkg::token_t            chain_tok [PALETTE_DEPTH+1];
    logic [PALETTE_DEPTH-1:0]    cell_wr_en;
    logic [PALETTE_DEPTH-1:0]    cell_active;

    // Search size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= npcs_pkg::SIZE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            palette_size_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        size_nz = (palette_size_reg == '0) ? npcs_pkg::SIZE_W'(1) : palette_size_reg;
        if (32'(size_nz) > 32'(PALETTE_DEPTH))
        begin
            eff_count = CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            eff_count = CNT_W'(size_nz);
        end
    end

    // Item side
    assign item.ready = !busy_reg;
    assign item_xfer  = item.valid && item.ready;
    assign load_xfer  = item_xfer && (item.cmd == npcs_pkg::CMD_LOAD);
    assign query_xfer = item_xfer && (item.cmd == npcs_pkg::CMD_QUERY);

    assign in_color.red   = item.in_red;
    assign in_color.green = item.in_green;
    assign in_color.blue  = item.in_blue;

    always_comb
    begin
        head_tok            = '0;
        head_tok.ref_color  = in_color;
        head_tok.best_dist  = npcs_pkg::DIST_NONE;
    end

    assign chain_valid[0] = query_xfer;
    assign chain_tok[0]   = head_tok;

    // Cell chain
    for (genvar g = 0; g < PALETTE_DEPTH; g++)
    begin : g_cell
        assign cell_wr_en[g]  = load_xfer && (32'(item.entry_index) == 32'(g));
        assign cell_active[g] = (32'(eff_count) > 32'(g));

        npcs_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .wr_en         (cell_wr_en[g]),
            .wr_color      (in_color),
            .active        (cell_active[g]),
            .tok_in_valid  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_out_valid (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    // Chain holds only when a finished token meets a full output register.
    assign advance  = !(chain_valid[PALETTE_DEPTH] && out_valid_reg && !result.ready);
    assign out_load = chain_valid[PALETTE_DEPTH] && advance;

    always_comb
    begin
        busy_next = busy_reg;
        priority if (query_xfer)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_tok_reg <= chain_tok[PALETTE_DEPTH];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.near_red         = out_tok_reg.best_color.red;
    assign result.near_green       = out_tok_reg.best_color.green;
    assign result.near_blue        = out_tok_reg.best_color.blue;
    assign result.near_index       = out_tok_reg.best_slot;
    assign result.near_sq_distance = out_tok_reg.best_dist;

endmodule

`default_nettype wire
